>>> src/imurm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imurm_pkg
// Shared types and constants of the inertial-sensor register map slave.
// ---------------------------------------------------------------------------
package imurm_pkg;

    // Bus event kind carried in tuser
    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_UPDATE = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic CFG_IDENTITY = 1'b0;
    localparam logic CFG_FREEZE   = 1'b1;

    // Register map addresses
    localparam logic [7:0] ADDR_SAMPLE_FIRST = 8'h3B;
    localparam logic [7:0] ADDR_SAMPLE_LAST  = 8'h48;
    localparam logic [7:0] ADDR_POWER_1      = 8'h6B;
    localparam logic [7:0] ADDR_POWER_2      = 8'h6C;
    localparam logic [7:0] ADDR_IDENTITY     = 8'h75;

    // Reset values
    localparam logic [7:0]  IDENTITY_DEFAULT = 8'h68;
    localparam logic [7:0]  POWER_1_DEFAULT  = 8'h40;
    localparam logic [15:0] TEMP_DEFAULT     = 16'hF0B0;   // -3920

    // Only 16 bytes of the map can change: 14 sample bytes and two power bytes
    localparam int LIVE_BYTES = 16;
    localparam int SLOT_W     = 4;
    localparam logic [SLOT_W-1:0] SLOT_TEMP_HI = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_TEMP_LO = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_POWER_1 = 4'd14;
    localparam logic [SLOT_W-1:0] SLOT_POWER_2 = 4'd15;

    // Controller to datapath command
    typedef struct packed {
        logic read;     // return byte at pointer, advance pointer
        logic write;    // load pointer or store power byte
        logic stop;     // clear pointer-loaded flag
        logic update;   // store sensor samples
    } t_dp_cmd;

endpackage

>>> src/imurm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imurm_ctrl
// Handshake controller: accepts bus events, issues datapath commands and
// tracks the output register.
// ---------------------------------------------------------------------------
module imurm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  imurm_pkg::t_mode  i_mode,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output imurm_pkg::t_dp_cmd o_cmd
);
    import imurm_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_state;

    t_state r_state;
    logic   accept;

    // output slot frees in the same cycle it is taken
    assign o_s_tready = (r_state == ST_EMPTY) || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_FULL);

    always_comb begin
        o_cmd = '0;
        if (accept) begin
            unique case (i_mode)
                MODE_READ:   o_cmd.read   = 1'b1;
                MODE_WRITE:  o_cmd.write  = 1'b1;
                MODE_STOP:   o_cmd.stop   = 1'b1;
                MODE_UPDATE: o_cmd.update = 1'b1;
                default:     o_cmd        = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            unique case (r_state)
                ST_EMPTY: begin
                    if (accept && i_mode == MODE_READ) r_state <= ST_FULL;
                end
                ST_FULL: begin
                    if (accept && i_mode == MODE_READ) r_state <= ST_FULL;
                    else if (i_m_tready)               r_state <= ST_EMPTY;
                end
                default: r_state <= ST_EMPTY;
            endcase
        end
    end

endmodule

>>> src/imurm_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imurm_dp
// Register map datapath: pointer, live register bytes, config registers
// and the read data register.
// ---------------------------------------------------------------------------
module imurm_dp #(
    parameter int MAP_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imurm_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]         i_bus_byte,
    input  logic [15:0]        i_accel_x,
    input  logic [15:0]        i_accel_y,
    input  logic [15:0]        i_accel_z,
    input  logic [15:0]        i_gyro_x,
    input  logic [15:0]        i_gyro_y,
    input  logic [15:0]        i_gyro_z,
    input  logic [15:0]        i_temperature,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_wdata,
    output logic [7:0]         o_read_data
);
    import imurm_pkg::*;

    logic [7:0] r_live [LIVE_BYTES];
    logic [7:0] r_pointer;
    logic       r_loaded;
    logic [7:0] r_identity;
    logic       r_freeze;
    logic [7:0] r_read_data;

    logic [8:0]        wrapped;
    logic [7:0]        map_addr;
    logic              live_hit;
    logic [SLOT_W-1:0] live_slot;
    logic [8:0]        sample_off;
    logic [7:0]        rd_byte;
    logic              power_hit;

    // pointer mod MAP_DEPTH: value stays below twice the depth
    assign wrapped  = {1'b0, r_pointer} - 9'(MAP_DEPTH);
    assign map_addr = ({1'b0, r_pointer} >= 9'(MAP_DEPTH)) ? wrapped[7:0] : r_pointer;

    assign sample_off = {1'b0, map_addr} - {1'b0, ADDR_SAMPLE_FIRST};

    always_comb begin
        live_hit  = 1'b0;
        live_slot = '0;
        if (map_addr >= ADDR_SAMPLE_FIRST && map_addr <= ADDR_SAMPLE_LAST) begin
            live_hit  = 1'b1;
            live_slot = sample_off[SLOT_W-1:0];
        end else if (map_addr == ADDR_POWER_1) begin
            live_hit  = 1'b1;
            live_slot = SLOT_POWER_1;
        end else if (map_addr == ADDR_POWER_2) begin
            live_hit  = 1'b1;
            live_slot = SLOT_POWER_2;
        end
    end

    assign power_hit = (map_addr == ADDR_POWER_1) || (map_addr == ADDR_POWER_2);

    always_comb begin
        if (map_addr == ADDR_IDENTITY) rd_byte = r_identity;
        else if (live_hit)             rd_byte = r_live[live_slot];
        else                           rd_byte = 8'h00;
    end

    // control and map state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer  <= '0;
            r_loaded   <= 1'b0;
            r_identity <= IDENTITY_DEFAULT;
            r_freeze   <= 1'b0;
            for (int i = 0; i < LIVE_BYTES; i++) r_live[i] <= 8'h00;
            r_live[SLOT_TEMP_HI] <= TEMP_DEFAULT[15:8];
            r_live[SLOT_TEMP_LO] <= TEMP_DEFAULT[7:0];
            r_live[SLOT_POWER_1] <= POWER_1_DEFAULT;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDENTITY: r_identity <= i_cfg_wdata;
                    CFG_FREEZE:   r_freeze   <= i_cfg_wdata[0];
                    default:      ;
                endcase
            end
            if (i_cmd.read) begin
                r_pointer <= r_pointer + 8'd1;
            end
            if (i_cmd.write) begin
                if (!r_loaded) begin
                    r_pointer <= i_bus_byte;
                    r_loaded  <= 1'b1;
                end else begin
                    if (power_hit) r_live[live_slot] <= i_bus_byte;
                    r_pointer <= r_pointer + 8'd1;
                end
            end
            if (i_cmd.stop) begin
                r_loaded <= 1'b0;
            end
            if (i_cmd.update && !r_freeze) begin
                // big-endian words at 0x3B: ax ay az temp gx gy gz
                r_live[0]  <= i_accel_x[15:8];
                r_live[1]  <= i_accel_x[7:0];
                r_live[2]  <= i_accel_y[15:8];
                r_live[3]  <= i_accel_y[7:0];
                r_live[4]  <= i_accel_z[15:8];
                r_live[5]  <= i_accel_z[7:0];
                r_live[6]  <= i_temperature[15:8];
                r_live[7]  <= i_temperature[7:0];
                r_live[8]  <= i_gyro_x[15:8];
                r_live[9]  <= i_gyro_x[7:0];
                r_live[10] <= i_gyro_y[15:8];
                r_live[11] <= i_gyro_y[7:0];
                r_live[12] <= i_gyro_z[15:8];
                r_live[13] <= i_gyro_z[7:0];
            end
        end
    end

    // read data register, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) r_read_data <= rd_byte;
    end

    assign o_read_data = r_read_data;

endmodule

>>> src/imu_register_map_bus_slave.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imu_register_map_bus_slave
// Emulated inertial-sensor register map behind a byte bus slave.
// ---------------------------------------------------------------------------
// Each slave transfer is one bus event, selected by tuser: read request,
// written byte, stop/restart, or sensor update. A read request returns one
// master transfer carrying the byte at the register pointer (pointer taken
// modulo MAP_DEPTH, address 0x75 returns the identity register), after which
// the pointer advances and wraps at 256. The first byte written after a
// stop/restart loads the pointer; later written bytes land only at 0x6B and
// 0x6C and advance the pointer either way. A sensor update stores seven
// 16-bit samples big-endian from 0x3B (accel xyz, temperature, gyro xyz)
// unless freeze_updates is set. The read byte sits in a single output
// register; a new event is accepted whenever that register is empty or is
// being drained in the same cycle, so the slave side only stalls while an
// unread result is held there. Configuration writes (index 0 identity_value,
// index 1 freeze_updates) take effect on the write edge and are to be
// issued while the block idles.
// ---------------------------------------------------------------------------
module imu_register_map_bus_slave #(
    parameter int MAP_DEPTH = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [7:0] bus_byte, [23:8] accel_x, [39:24] accel_y, [55:40] accel_z,
    // [71:56] gyro_x, [87:72] gyro_y, [103:88] gyro_z, [119:104] temperature
    input  logic [119:0] i_s_tdata,
    input  logic [1:0]   i_s_tuser,     // [1:0] mode
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [7:0]   o_m_tdata,     // [7:0] read_data
    // configuration
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [7:0]   i_cfg_wdata
);
    import imurm_pkg::*;

    t_dp_cmd cmd;
    t_mode   mode;

    assign mode = t_mode'(i_s_tuser);

    imurm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (mode),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    imurm_dp #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_bus_byte    (i_s_tdata[7:0]),
        .i_accel_x     (i_s_tdata[23:8]),
        .i_accel_y     (i_s_tdata[39:24]),
        .i_accel_z     (i_s_tdata[55:40]),
        .i_gyro_x      (i_s_tdata[71:56]),
        .i_gyro_y      (i_s_tdata[87:72]),
        .i_gyro_z      (i_s_tdata[103:88]),
        .i_temperature (i_s_tdata[119:104]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_read_data   (o_m_tdata)
    );

endmodule
